// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the tone generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define STS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define STS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define STS_ASSERT(lbl, clk, rst, prop, msg)
`define STS_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== design/sts_pkg.sv =====
// Shared constants and types of the sine tone sample generator.
`default_nettype none

package sts_pkg;

   // Sizes
   localparam int TABLE_ADDR_BITS = 10;
   localparam int PHASE_BITS      = 32;
   localparam int TOP_BITS        = TABLE_ADDR_BITS + 2;
   localparam int QTR_SIZE        = 1 << TABLE_ADDR_BITS;
   localparam int ROM_ADDR_BITS   = TABLE_ADDR_BITS + 1;
   localparam int ENTRY_BITS      = 31;
   localparam int MAG_BITS        = 15;
   localparam int WORD_BITS       = 16;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int COUNT_BITS      = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_SAMPLES = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDE_MODE     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEREO_MODE   = 2'd3;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] PHASE_STEP_RESET    = 32'd42852281;
   localparam logic [COUNT_BITS-1:0]    TOTAL_SAMPLES_RESET = 32'd176400;

   // Output scaling
   localparam logic [MAG_BITS-1:0] AMP_WIDE      = 15'd32767;
   localparam logic [MAG_BITS-1:0] AMP_NARROW    = 15'd127;
   localparam logic [7:0]          NARROW_OFFSET = 8'd128;

   // Mode registers as seen by the back end
   typedef struct packed {
      logic wide;
      logic stereo;
   } cfg_type;

   // One tick's work handed from front to back
   typedef struct packed {
      logic [1:0]                 quad;
      logic [TABLE_ADDR_BITS-1:0] idx;
      logic                       fin;
   } job_type;

endpackage

`default_nettype wire

// ===== design/sts_front.sv =====
// Front end: mode registers, tick acceptance, phase accumulator and sample count.
`default_nettype none

module sts_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [sts_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_restart,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output sts_pkg::job_type                         q_job,
   output sts_pkg::cfg_type                         cfg
);

   logic [sts_pkg::PHASE_BITS-1:0] step_ff, step_in;
   logic [sts_pkg::COUNT_BITS-1:0] total_ff, total_in;
   logic                           wide_ff, wide_in;
   logic                           stereo_ff, stereo_in;
   logic [sts_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic [sts_pkg::COUNT_BITS-1:0] left_ff, left_in;
   logic [sts_pkg::PHASE_BITS-1:0] phase_base;
   logic [sts_pkg::COUNT_BITS-1:0] left_base;
   logic [sts_pkg::TOP_BITS-1:0]   top;
   logic                           accept;
   logic                           active;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Register writes
   always_comb begin
      step_in   = step_ff;
      total_in  = total_ff;
      wide_in   = wide_ff;
      stereo_in = stereo_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sts_pkg::CSR_PHASE_STEP:    step_in   = csr_wdata[sts_pkg::PHASE_BITS-1:0];
            sts_pkg::CSR_TOTAL_SAMPLES: total_in  = csr_wdata[sts_pkg::COUNT_BITS-1:0];
            sts_pkg::CSR_WIDE_MODE:     wide_in   = csr_wdata[0];
            sts_pkg::CSR_STEREO_MODE:   stereo_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Restart applies before the tick is classified
   assign phase_base = req_restart ? '0 : phase_ff;
   assign left_base  = req_restart ? total_ff : left_ff;
   assign active     = (left_base != '0);
   assign top        = phase_base[sts_pkg::PHASE_BITS-1 -: sts_pkg::TOP_BITS];

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      if (accept) begin
         if (active) begin
            phase_in = phase_base + step_ff;
            left_in  = left_base - 1'b1;
         end else begin
            phase_in = phase_base;
            left_in  = left_base;
         end
      end
   end

   // Job for the back end
   assign q_push     = accept && active;
   assign q_job.quad = top[sts_pkg::TOP_BITS-1 -: 2];
   assign q_job.idx  = top[sts_pkg::TABLE_ADDR_BITS-1:0];
   assign q_job.fin  = (left_base == sts_pkg::COUNT_BITS'(1));

   assign cfg.wide   = wide_ff;
   assign cfg.stereo = stereo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= sts_pkg::PHASE_STEP_RESET[sts_pkg::PHASE_BITS-1:0];
         total_ff  <= sts_pkg::TOTAL_SAMPLES_RESET;
         wide_ff   <= 1'b1;
         stereo_ff <= 1'b0;
         phase_ff  <= '0;
         left_ff   <= sts_pkg::TOTAL_SAMPLES_RESET;
      end else begin
         step_ff   <= step_in;
         total_ff  <= total_in;
         wide_ff   <= wide_in;
         stereo_ff <= stereo_in;
         phase_ff  <= phase_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sts_queue.sv =====
// Short job queue between the front and back ends.
`default_nettype none

module sts_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sts_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output sts_pkg::job_type      head_job
);

   sts_pkg::job_type                  entries_ff [sts_pkg::QUEUE_DEPTH];
   logic [sts_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sts_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sts_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full       = (count_ff == (sts_pkg::QUEUE_PTR_BITS+1)'(sts_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   // Pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sts_back.sv =====
// Back end: quarter-wave table lookup, amplitude scaling and output word beats.
`default_nettype none

module sts_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sts_pkg::cfg_type                cfg,
   input  wire logic                            q_valid,
   input  wire sts_pkg::job_type                q_job,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [sts_pkg::WORD_BITS-1:0]        rsp_pcm_word,
   output logic                                 rsp_right_channel,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_final_sample
);

   typedef logic [sts_pkg::ENTRY_BITS-1:0] sine_rom_type [sts_pkg::QTR_SIZE+1];

   localparam logic [63:0] HALF_PI_Q44 = 64'h1921FB54442D1846 >> 16;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Taylor term divisors (2n)(2n+1)
   function automatic logic [63:0] term_divisor(input int n);
      logic [63:0] d;
      case (n)
         1:       d = 64'd6;
         2:       d = 64'd20;
         3:       d = 64'd42;
         4:       d = 64'd72;
         5:       d = 64'd110;
         6:       d = 64'd156;
         7:       d = 64'd210;
         8:       d = 64'd272;
         9:       d = 64'd342;
         10:      d = 64'd420;
         11:      d = 64'd506;
         default: d = 64'd600;
      endcase
      return d;
   endfunction

   // Restoring long division, truncated quotient; only used to build the table
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(k*pi/2 / QTR_SIZE) in Q1.30, series evaluated at elaboration
   function automatic logic [sts_pkg::ENTRY_BITS-1:0] quarter_sine(input int k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [65:0] s;
      int                 n;
      x  = (HALF_PI_Q44 * 64'(k)) >> (sts_pkg::TABLE_ADDR_BITS + 14);
      x2 = (x * x) >> 30;
      t  = x;
      s  = signed'({2'b00, x});
      for (n = 1; n <= 12; n++) begin
         t = long_div((t * x2) >> 30, term_divisor(n));
         if ((n & 1) != 0) begin
            s = s - signed'({2'b00, t});
         end else begin
            s = s + signed'({2'b00, t});
         end
      end
      if (s < 0) begin
         s = '0;
      end
      if (s > signed'({2'b00, ONE_Q30})) begin
         s = signed'({2'b00, ONE_Q30});
      end
      return s[sts_pkg::ENTRY_BITS-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      int           k;
      for (k = 0; k <= sts_pkg::QTR_SIZE; k++) begin
         rom[k] = quarter_sine(k);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic                                  s1_valid_ff, s1_valid_in;
   logic [sts_pkg::ENTRY_BITS-1:0]        s1_entry_ff;
   logic                                  s1_neg_ff;
   logic                                  s1_fin_ff;
   logic                                  s2_valid_ff, s2_valid_in;
   logic [sts_pkg::MAG_BITS-1:0]          s2_mag_ff;
   logic                                  s2_neg_ff;
   logic                                  s2_fin_ff;
   logic                                  out_valid_ff, out_valid_in;
   logic                                  out_beat_ff, out_beat_in;
   logic [sts_pkg::WORD_BITS-1:0]         out_word_ff, out_word_in;
   logic                                  out_fin_ff;
   logic [sts_pkg::ROM_ADDR_BITS-1:0]     rom_addr;
   logic [sts_pkg::MAG_BITS-1:0]          amp;
   logic [sts_pkg::ENTRY_BITS+sts_pkg::MAG_BITS-1:0] product;
   logic [sts_pkg::WORD_BITS-1:0]         signed_word;
   logic [7:0]                            narrow_byte;
   logic                                  out_take;
   logic                                  out_free;
   logic                                  s2_free;
   logic                                  s1_free;

   // Stall chain, output side first
   assign out_take = rsp_valid && rsp_ready && rsp_last_of_run;
   assign out_free = !out_valid_ff || out_take;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign q_pop    = q_valid && s1_free;

   // Quadrants 1 and 3 mirror the index
   assign rom_addr = q_job.quad[0]
                   ? sts_pkg::ROM_ADDR_BITS'(sts_pkg::QTR_SIZE) - {1'b0, q_job.idx}
                   : {1'b0, q_job.idx};

   // Scale by amplitude, truncation toward zero
   assign amp     = cfg.wide ? sts_pkg::AMP_WIDE : sts_pkg::AMP_NARROW;
   assign product = s1_entry_ff * amp;

   // Sign and offset
   assign signed_word = s2_neg_ff ? (sts_pkg::WORD_BITS'(0) - {1'b0, s2_mag_ff})
                                  : {1'b0, s2_mag_ff};
   assign narrow_byte = signed_word[7:0] + sts_pkg::NARROW_OFFSET;

   always_comb begin
      s1_valid_in  = s1_free ? q_valid : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_valid_ff;
      out_beat_in  = out_beat_ff;
      out_word_in  = cfg.wide ? signed_word : {8'h00, narrow_byte};
      if (out_free) begin
         out_valid_in = s2_valid_ff;
         out_beat_in  = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         out_beat_in = 1'b1;
      end
   end

   // Table read stage
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_entry_ff <= SINE_ROM[rom_addr];
         s1_neg_ff   <= q_job.quad[1];
         s1_fin_ff   <= q_job.fin;
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_mag_ff <= product[30 +: sts_pkg::MAG_BITS];
         s2_neg_ff <= s1_neg_ff;
         s2_fin_ff <= s1_fin_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_word_ff <= out_word_in;
         out_fin_ff  <= s2_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_beat_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         out_beat_ff  <= out_beat_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pcm_word      = out_word_ff;
   assign rsp_right_channel = out_beat_ff;
   assign rsp_last_of_run   = !cfg.stereo || out_beat_ff;
   assign rsp_final_sample  = out_fin_ff;

endmodule

`default_nettype wire

// ===== design/sine_tone_sample_generator.sv =====
// Top level of the sine tone sample generator: front end, job queue, back end.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//   req     | in        | req_valid/req_ready  | req_restart
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_pcm_word, rsp_right_channel,
//           |           |                      | rsp_last_of_run, rsp_final_sample
//
// A tick is taken every cycle while the two-entry job queue has room; its first word
// passes the queue entry, table read, multiply and output registers before it is valid.
// The output register sets the pace: one word per tick in mono, two per tick in stereo
// (left word, then right word).
// Reset is synchronous; the sine table is a constant ROM, so no clearing pass.
// Either side may stall; the queue and the back end stages hold their words.
`default_nettype none

`include "assert_macros.svh"

module sine_tone_sample_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sts_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sts_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_restart,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [sts_pkg::WORD_BITS-1:0]           rsp_pcm_word,
   output logic                                    rsp_right_channel,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_final_sample
);

   sts_pkg::cfg_type cfg;
   sts_pkg::job_type push_job;
   sts_pkg::job_type head_job;
   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;

   sts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .cfg         (cfg)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   sts_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_job             (head_job),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pcm_word      (rsp_pcm_word),
      .rsp_right_channel (rsp_right_channel),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_final_sample  (rsp_final_sample)
   );

   // Right copies only exist in stereo
   `STS_NEVER(a_right_needs_stereo, clock, reset,
              rsp_valid && rsp_right_channel && !cfg.stereo,
              "right word outside stereo mode")
   // A taken left word is followed by its right copy with the same final flag
   `STS_ASSERT(a_right_follows_left, clock, reset,
               rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_right_channel
                  && (rsp_final_sample == $past(rsp_final_sample)),
               "right word did not follow left word")
   // Narrow samples keep the high byte clear
   `STS_NEVER(a_narrow_high_byte, clock, reset,
              rsp_valid && !cfg.wide && (rsp_pcm_word[15:8] != 8'h00),
              "narrow sample with nonzero high byte")
   // The queue never takes a job while full
   `STS_NEVER(a_no_push_when_full, clock, reset, q_push && q_full,
              "job pushed into full queue")

endmodule

`default_nettype wire

// ===== test/tb_sine_tone_sample_generator.sv =====
// Self-checking testbench for the sine tone sample generator: random ticks, checked words.
module tb_sine_tone_sample_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 24;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int TICK_TARGET     = 1300;
   localparam int MAX_GAP         = 19;

   // pi/2 in Q44 and one in Q30 for the quarter-wave table
   localparam longint unsigned HALF_PI_Q44 = 64'h1921FB54442D1846 >> 16;
   localparam longint          ONE_Q30     = 64'sd1 << 30;
   localparam longint unsigned AMP16       = 64'd32767;
   localparam longint unsigned AMP8        = 64'd127;

   typedef struct packed {
      logic [sts_pkg::WORD_BITS-1:0] pcm;
      logic                          right;
      logic                          last;
      logic                          fin;
   } pcm_result_type;

   // Block ports
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [sts_pkg::CSR_INDEX_BITS-1:0] csr_index = sts_pkg::CSR_PHASE_STEP;
   logic [sts_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_restart = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [sts_pkg::WORD_BITS-1:0]      rsp_pcm_word;
   logic                               rsp_right_channel;
   logic                               rsp_last_of_run;
   logic                               rsp_final_sample;

   // Predictor state and register copies
   longint unsigned                sine_entry [0:sts_pkg::QTR_SIZE];
   logic [sts_pkg::PHASE_BITS-1:0] tone_phase = '0;
   logic [sts_pkg::COUNT_BITS-1:0] ticks_left = sts_pkg::TOTAL_SAMPLES_RESET;
   logic [31:0]                    cfg_step   = sts_pkg::PHASE_STEP_RESET;
   logic [sts_pkg::COUNT_BITS-1:0] cfg_total  = sts_pkg::TOTAL_SAMPLES_RESET;
   logic                           cfg_wide   = 1'b1;
   logic                           cfg_stereo = 1'b0;
   pcm_result_type                 sample_words_due [$];

   // Stimulus bookkeeping
   logic pending_ticks [$];
   int   ticks_queued    = 0;
   int   ticks_taken     = 0;
   int   mismatch_count  = 0;
   int   idle_cycles     = 0;
   int   req_gap         = 0;
   int   rsp_hold        = 0;
   logic req_taken       = 1'b0;
   logic rsp_taken       = 1'b0;
   logic req_idle_on     = 1'b1;
   logic rsp_idle_on     = 1'b1;

   sine_tone_sample_generator u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pcm_word      (rsp_pcm_word),
      .rsp_right_channel (rsp_right_channel),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_final_sample  (rsp_final_sample)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Table lookup, scaling and offset for one phase value
   function automatic logic [sts_pkg::WORD_BITS-1:0] tone_sample(
         input logic [sts_pkg::PHASE_BITS-1:0] phase);
      logic [sts_pkg::TOP_BITS-1:0] top_bits;
      logic [1:0]                   quad;
      int unsigned                  entry_idx;
      longint unsigned              mag;
      logic [31:0]                  val;
      top_bits  = phase[sts_pkg::PHASE_BITS-1 -: sts_pkg::TOP_BITS];
      quad      = top_bits[sts_pkg::TOP_BITS-1 -: 2];
      entry_idx = top_bits[sts_pkg::TABLE_ADDR_BITS-1:0];
      if (quad[0])
         entry_idx = sts_pkg::QTR_SIZE - entry_idx;
      mag = (sine_entry[entry_idx] * (cfg_wide ? AMP16 : AMP8)) >> 30;
      val = mag[31:0];
      if (quad[1])
         val = -val;
      if (cfg_wide)
         return val[15:0];
      return {8'h00, val[7:0] + 8'd128};
   endfunction

   // Advance the tone by one tick and queue the words it should produce
   function automatic void predict_tone_tick(input logic restart);
      pcm_result_type w;
      if (restart) begin
         tone_phase = '0;
         ticks_left = cfg_total;
      end
      // tone finished: no word, phase holds
      if (ticks_left == 0)
         return;
      w.pcm      = tone_sample(tone_phase);
      tone_phase = tone_phase + cfg_step[sts_pkg::PHASE_BITS-1:0];
      ticks_left = ticks_left - 1;
      w.fin      = (ticks_left == 0);
      w.right    = 1'b0;
      w.last     = !cfg_stereo;
      sample_words_due.push_back(w);
      if (cfg_stereo) begin
         w.right = 1'b1;
         w.last  = 1'b1;
         sample_words_due.push_back(w);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_word();
      pcm_result_type want;
      if (sample_words_due.size() == 0) begin
         report_mismatch($sformatf("unexpected word pcm=0x%04h", rsp_pcm_word));
      end else begin
         want = sample_words_due.pop_front();
         if (rsp_pcm_word !== want.pcm)
            report_mismatch($sformatf("pcm_word 0x%04h, want 0x%04h", rsp_pcm_word, want.pcm));
         if (rsp_right_channel !== want.right)
            report_mismatch($sformatf("right_channel %b, want %b",
                                      rsp_right_channel, want.right));
         if (rsp_last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %b, want %b", rsp_last_of_run, want.last));
         if (rsp_final_sample !== want.fin)
            report_mismatch($sformatf("final_sample %b, want %b", rsp_final_sample, want.fin));
      end
   endtask

   // Monitor: register writes, accepted ticks, accepted words, watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         rsp_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sts_pkg::CSR_PHASE_STEP:    cfg_step   = csr_wdata;
               sts_pkg::CSR_TOTAL_SAMPLES: cfg_total  = csr_wdata;
               sts_pkg::CSR_WIDE_MODE:     cfg_wide   = csr_wdata[0];
               sts_pkg::CSR_STEREO_MODE:   cfg_stereo = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_tone_tick(req_restart);
            ticks_taken++;
         end
         if (rsp_valid && rsp_ready)
            check_word();
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("tb_sine_tone_sample_generator: FAIL");
            $finish;
         end
      end
   end

   // Tick driver: holds each tick until taken, then waits its drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            req_valid   <= 1'b1;
            req_restart <= pending_ticks.pop_front();
            req_gap     = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result sink: stalls a drawn number of cycles before each word
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken)
            rsp_hold = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_register(input logic [sts_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [sts_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_tone(input logic [31:0] step, input logic [31:0] total,
                           input logic wide, input logic stereo);
      write_register(sts_pkg::CSR_PHASE_STEP, step);
      write_register(sts_pkg::CSR_TOTAL_SAMPLES, total);
      write_register(sts_pkg::CSR_WIDE_MODE, {31'd0, wide});
      write_register(sts_pkg::CSR_STEREO_MODE, {31'd0, stereo});
   endtask

   task automatic queue_tick(input logic restart);
      pending_ticks.push_back(restart);
      ticks_queued++;
   endtask

   // Wait for every tick taken and every word seen, then let the pipe drain
   task automatic wait_idle();
      do @(negedge clock);
      while (ticks_taken != ticks_queued || sample_words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
   endtask

   initial begin
      longint unsigned x, x2, t;
      longint          s;
      logic [31:0]     step, total;
      int              n_ticks;
      int              phase_count;

      // Quarter-wave table in Q30 by a truncated Taylor series
      for (int k = 0; k <= sts_pkg::QTR_SIZE; k++) begin
         x  = (HALF_PI_Q44 * 64'(k)) >> (sts_pkg::TABLE_ADDR_BITS + 14);
         x2 = (x * x) >> 30;
         t  = x;
         s  = longint'(x);
         for (int n = 1; n <= 12; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
               s -= longint'(t);
            else
               s += longint'(t);
         end
         if (s < 0)
            s = 0;
         if (s > ONE_Q30)
            s = ONE_Q30;
         sine_entry[k] = longint'(s);
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Registers at reset values, state straight out of reset
      for (int i = 0; i < 3; i++)
         queue_tick(1'b0);
      queue_tick(1'b1);
      wait_idle();

      // Quarter-turn step in stereo: one left and right word pair per quadrant, then tone finished
      set_tone(32'h4000_0000, 32'd6, 1'b1, 1'b1);
      queue_tick(1'b1);
      for (int i = 0; i < 6; i++)
         queue_tick(1'b0);
      wait_idle();

      // Narrow samples with the largest step: phase wraps on the second add
      set_tone(32'hFFFF_FFFF, 32'd3, 1'b0, 1'b0);
      queue_tick(1'b1);
      for (int i = 0; i < 3; i++)
         queue_tick(1'b0);
      wait_idle();

      // Zero total: restart gives nothing; zero step
      set_tone(32'd0, 32'd0, 1'b1, 1'b0);
      queue_tick(1'b1);
      queue_tick(1'b0);
      wait_idle();

      // One table point per tick, longest possible tone
      set_tone(32'h0010_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_tick(1'b1);
      for (int i = 0; i < 3; i++)
         queue_tick(1'b0);
      wait_idle();

      // Random tones: mostly short runs opened by a restart
      phase_count = 0;
      while (ticks_queued < TICK_TARGET && phase_count < 400) begin
         case ($urandom_range(0, 5))
            0:       step = $urandom();
            1:       step = $urandom_range(0, 1 << 24);
            2:       step = {12'($urandom_range(0, 4095)), 20'd0};
            3:       step = 32'hFFFF_FFFF - $urandom_range(0, 1 << 22);
            4:       step = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: step = $urandom_range(1 << 20, 1 << 28);
         endcase
         case ($urandom_range(0, 9))
            0:       total = 32'd0;
            1:       total = 32'd1;
            2:       total = $urandom();
            3:       total = 32'hFFFF_FFFF;
            default: total = $urandom_range(1, 60);
         endcase
         set_tone(step, total, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         n_ticks = $urandom_range(8, 70);
         queue_tick($urandom_range(0, 7) != 0);
         for (int i = 1; i < n_ticks; i++)
            queue_tick($urandom_range(0, 24) == 0);
         wait_idle();
         phase_count++;
      end

      if (sample_words_due.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", sample_words_due.size()));
      if (mismatch_count == 0)
         $display("tb_sine_tone_sample_generator: PASS");
      else
         $display("tb_sine_tone_sample_generator: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/sts_pkg.sv
design/sts_front.sv
design/sts_queue.sv
design/sts_back.sv
design/sine_tone_sample_generator.sv
test/tb_sine_tone_sample_generator.sv
